// ===== rtl/iprbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range lookup package
// Shared sizes, entry and result layouts and the search sequencer states.
// ----------------------------------------------------------------------------
package iprbl_pkg;

    // Table size and the address width of the range memory.
    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // Widths of the word fields.
    localparam int IDX_W  = 16;
    localparam int IP_W   = 32;
    localparam int OFS_W  = 24;
    localparam int CNT_W  = 17;

    // Largest usable entry count: limited by the table and by the 16-bit index.
    localparam int SPAN_CAP = (TABLE_DEPTH < 65536) ? TABLE_DEPTH : 65536;

    // Input word kinds carried on tuser.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // One table entry as held in the range memory.
    typedef struct packed {
        logic [OFS_W-1:0] offset;
        logic [IP_W-1:0]  stop;
        logic [IP_W-1:0]  start;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One input word after unpacking.
    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] entry_index;
        entry_t           entry;
        logic [IP_W-1:0]  query_address;
    } item_t;

    // One lookup result.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_index;
        entry_t           entry;
    } result_t;

    // Access requests from the search sequencer to the range memory.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    // Search sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_DONE
    } state_t;

    // Map a 16-bit entry index onto the memory address width.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = {16'd0, idx};
        return wide[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/ip_range_binary_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range binary lookup
// Holds a table of sorted IPv4 ranges and answers address queries by binary
// search over the first entry_count entries.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_*       in         tuser: mode; tdata: index, start, stop, offset, address
//  m_*       out        tuser: found; tdata: index, start, stop, offset
//  cfg_*     in         entry_count, written whenever cfg_wr_en is high
//
// A load word is accepted in the idle state and produces no result.
// A query makes at most 17 memory probes for a full table, and a miss ends
// when the interval runs empty; each probe is the registered read of the
// range memory followed by the bound compare.
// Reset clears the count and the sequencer; the memory is not cleared.
// A stalled result sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module ip_range_binary_lookup (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Entry count register
    input  logic                          cfg_wr_en,
    input  logic [iprbl_pkg::CNT_W-1:0]   cfg_wr_data,
    // Input words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [135:0]                  s_tdata,  // entry_index, range_start,
                                                    // range_stop, info_offset,
                                                    // query_address
    input  logic                          s_tuser,  // mode
    // Result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,  // hit_index, hit_start,
                                                    // hit_stop, hit_offset
    output logic                          m_tuser   // found
);

    iprbl_pkg::item_t    item;
    iprbl_pkg::mem_req_t mem_req;
    iprbl_pkg::entry_t   mem_rd_data;
    iprbl_pkg::result_t  res;
    logic                res_valid;
    logic                res_ready;

    // Unpack the input word.
    always_comb begin
        item.mode          = s_tuser;
        item.entry_index   = s_tdata[15:0];
        item.entry.start   = s_tdata[47:16];
        item.entry.stop    = s_tdata[79:48];
        item.entry.offset  = s_tdata[103:80];
        item.query_address = s_tdata[135:104];
    end

    iprbl_ram #(
        .DEPTH (iprbl_pkg::TABLE_DEPTH),
        .WIDTH (iprbl_pkg::ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    iprbl_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item        (item),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    iprbl_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== rtl/iprbl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iprbl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/iprbl_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range search sequencer
// Writes load words into the range memory and runs the binary search for
// query words, one memory probe per pass through the probe and check states.
// ----------------------------------------------------------------------------
module iprbl_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Entry count register
    input  logic                                cfg_wr_en,
    input  logic [iprbl_pkg::CNT_W-1:0]         cfg_wr_data,
    // Input words
    input  logic                                item_valid,
    output logic                                item_ready,
    input  iprbl_pkg::item_t                    item,
    // Range memory
    output iprbl_pkg::mem_req_t                 mem_req,
    input  iprbl_pkg::entry_t                   mem_rd_data,
    // Results
    output logic                                res_valid,
    input  logic                                res_ready,
    output iprbl_pkg::result_t                  res
);

    localparam logic [iprbl_pkg::CNT_W-1:0] CAP = iprbl_pkg::CNT_W'(iprbl_pkg::SPAN_CAP);

    iprbl_pkg::state_t                  state_reg, state_next;
    logic [iprbl_pkg::CNT_W-1:0]        count_reg;
    logic [iprbl_pkg::CNT_W-1:0]        lo_reg, lo_next;
    logic [iprbl_pkg::CNT_W-1:0]        hb_reg, hb_next;
    logic [iprbl_pkg::IDX_W-1:0]        mid_reg, mid_next;
    logic [iprbl_pkg::IP_W-1:0]         query_reg, query_next;
    iprbl_pkg::result_t                 res_reg, res_next;

    logic [iprbl_pkg::CNT_W-1:0]        usable_count;
    logic [iprbl_pkg::CNT_W:0]          mid_sum;
    logic [iprbl_pkg::IDX_W-1:0]        mid_calc;
    logic                               accept;
    logic                               load_in_range;

    // Entry count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // Count clipped to what the table and the index can address.
    assign usable_count = (count_reg > CAP) ? CAP : count_reg;

    // Probe point: floor of (lo + hi) / 2 with hi held as an exclusive bound.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hb_reg} - (iprbl_pkg::CNT_W+1)'(1);
    assign mid_calc = mid_sum[iprbl_pkg::IDX_W:1];

    assign accept        = item_valid && item_ready;
    assign load_in_range = (32'(item.entry_index) < iprbl_pkg::TABLE_DEPTH);

    // Memory requests: loads write in the idle state, probes always read at mid.
    always_comb begin
        mem_req.wr_en   = accept && (item.mode == iprbl_pkg::MODE_LOAD) && load_in_range;
        mem_req.wr_addr = iprbl_pkg::to_addr(item.entry_index);
        mem_req.wr_data = item.entry;
        mem_req.rd_addr = iprbl_pkg::to_addr(mid_calc);
    end

    // State and search registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iprbl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hb_reg    <= hb_next;
        mid_reg   <= mid_next;
        query_reg <= query_next;
        res_reg   <= res_next;
    end

    // Next state and outputs.
    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hb_next    = hb_reg;
        mid_next   = mid_reg;
        query_next = query_reg;
        res_next   = res_reg;
        item_ready = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            iprbl_pkg::ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid && item.mode == iprbl_pkg::MODE_QUERY) begin
                    query_next = item.query_address;
                    lo_next    = '0;
                    hb_next    = usable_count;
                    state_next = iprbl_pkg::ST_PROBE;
                end
            end
            iprbl_pkg::ST_PROBE: begin
                // An empty interval ends the search with a miss.
                if (lo_reg < hb_reg) begin
                    mid_next   = mid_calc;
                    state_next = iprbl_pkg::ST_CHECK;
                end else begin
                    res_next   = '0;
                    state_next = iprbl_pkg::ST_DONE;
                end
            end
            iprbl_pkg::ST_CHECK: begin
                // Memory data for the probe at mid is now valid.
                if (query_reg < mem_rd_data.start) begin
                    hb_next    = {1'b0, mid_reg};
                    state_next = iprbl_pkg::ST_PROBE;
                end else if (query_reg > mem_rd_data.stop) begin
                    lo_next    = {1'b0, mid_reg} + iprbl_pkg::CNT_W'(1);
                    state_next = iprbl_pkg::ST_PROBE;
                end else begin
                    res_next.found     = 1'b1;
                    res_next.hit_index = mid_reg;
                    res_next.entry     = mem_rd_data;
                    state_next         = iprbl_pkg::ST_DONE;
                end
            end
            iprbl_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = iprbl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iprbl_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ===== rtl/iprbl_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result output register
// Holds one result word for the master side and frees the search sequencer
// as soon as the word is taken.
// ----------------------------------------------------------------------------
module iprbl_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                res_valid,
    output logic                res_ready,
    input  iprbl_pkg::result_t  res,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,
    output logic                m_tuser
);

    logic               valid_reg;
    iprbl_pkg::result_t data_reg;

    // The slot can take a word when empty or when the held word leaves now.
    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            data_reg <= res;
        end
    end

    // Pack the result word: index, start, stop, offset from the lowest bit up.
    assign m_tvalid = valid_reg;
    assign m_tuser  = data_reg.found;
    assign m_tdata  = {data_reg.entry.offset, data_reg.entry.stop,
                       data_reg.entry.start, data_reg.hit_index};

endmodule

// ===== rtl/iprbl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range lookup port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module iprbl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tuser
);

    // A stalled result word holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A miss reports zeros in every field.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 104'd0)
        else $error("miss result carries non-zero data");

    // A query keeps the input side busy while the search runs.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken during a search");

    // A load finishes in its own cycle, so the next word can follow at once.
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser |=> s_tready)
        else $error("input stalled after a load word");

endmodule

bind ip_range_binary_lookup iprbl_checker u_iprbl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/range_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range lookup checker
// Watches the input, result and count channels of the range lookup block.
// It keeps its own copy of the range table and of the entry count. It works
// out the answer to every accepted query by binary search and compares each
// result word, field by field, with the oldest answer still waiting.
// ----------------------------------------------------------------------------
module range_lookup_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [iprbl_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [135:0]                s_tdata,   // entry_index, range_start,
                                                   // range_stop, info_offset,
                                                   // query_address
    input  logic                        s_tuser,   // mode
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [103:0]                m_tdata,   // hit_index, hit_start,
                                                   // hit_stop, hit_offset
    input  logic                        m_tuser,   // found
    output int                          pending_words,
    output int                          fail_count
);

    // Mirror of the range table and of the count register.
    logic [iprbl_pkg::IP_W-1:0]  range_start_mem [iprbl_pkg::TABLE_DEPTH];
    logic [iprbl_pkg::IP_W-1:0]  range_stop_mem  [iprbl_pkg::TABLE_DEPTH];
    logic [iprbl_pkg::OFS_W-1:0] record_ofs_mem  [iprbl_pkg::TABLE_DEPTH];
    logic [iprbl_pkg::CNT_W-1:0] entry_count = '0;

    iprbl_pkg::result_t expected_hits [$];
    int                 mismatches = 0;
    int                 pending    = 0;

    assign fail_count    = mismatches;
    assign pending_words = pending;

    // Binary search over the usable part of the table. A probe above the
    // address pulls the upper bound down, a probe below pushes the lower
    // bound up, and a containing probe ends the search.
    function automatic iprbl_pkg::result_t search_ranges(
        input logic [iprbl_pkg::IP_W-1:0] addr);
        iprbl_pkg::result_t r;
        int                 lo;
        int                 hi;
        int                 mid;
        r  = '0;
        lo = 0;
        hi = ((entry_count > iprbl_pkg::SPAN_CAP) ? iprbl_pkg::SPAN_CAP
                                                  : int'(entry_count)) - 1;
        while (lo <= hi && !r.found) begin
            mid = (lo + hi) / 2;
            if (addr < range_start_mem[mid]) begin
                hi = mid - 1;
            end else if (addr > range_stop_mem[mid]) begin
                lo = mid + 1;
            end else begin
                r.found        = 1'b1;
                r.hit_index    = iprbl_pkg::IDX_W'(mid);
                r.entry.start  = range_start_mem[mid];
                r.entry.stop   = range_stop_mem[mid];
                r.entry.offset = record_ofs_mem[mid];
            end
        end
        return r;
    endfunction

    function automatic string describe(input iprbl_pkg::result_t r);
        return $sformatf("found=%0b index=%0d start=%h stop=%h offset=%h",
                         r.found, r.hit_index, r.entry.start, r.entry.stop,
                         r.entry.offset);
    endfunction

    // Track table loads, count writes and queries; check every result word.
    always @(posedge aclk) begin : watch
        iprbl_pkg::result_t want;
        iprbl_pkg::result_t got;
        if (!aresetn) begin
            entry_count = '0;
        end else begin
            if (cfg_wr_en) begin
                entry_count = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == iprbl_pkg::MODE_LOAD) begin
                    // A load aimed past the end of the table is dropped.
                    if (int'(s_tdata[15:0]) < iprbl_pkg::TABLE_DEPTH) begin
                        range_start_mem[s_tdata[15:0]] = s_tdata[47:16];
                        range_stop_mem[s_tdata[15:0]]  = s_tdata[79:48];
                        record_ofs_mem[s_tdata[15:0]]  = s_tdata[103:80];
                    end
                end else begin
                    expected_hits.push_back(search_ranges(s_tdata[135:104]));
                end
            end
            if (m_tvalid && m_tready) begin
                got.found        = m_tuser;
                got.hit_index    = m_tdata[15:0];
                got.entry.start  = m_tdata[47:16];
                got.entry.stop   = m_tdata[79:48];
                got.entry.offset = m_tdata[103:80];
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] result word with no query waiting: %s",
                                 $realtime, describe(got));
                    end
                end else begin
                    want = expected_hits.pop_front();
                    if (got.found !== want.found || got.hit_index !== want.hit_index ||
                        got.entry.start !== want.entry.start ||
                        got.entry.stop !== want.entry.stop ||
                        got.entry.offset !== want.entry.offset) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] lookup mismatch", $realtime);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end
        end
        pending = expected_hits.size();
    end

endmodule

// ===== tb/tb_ip_range_binary_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 range lookup testbench
// Runs directed and random phases of table loads, count writes and address
// queries under several idling patterns on both channels, including one long
// result stall. Searches over the full table use a fixed range layout and
// load every slot on the probe path before the query goes in. Checking is
// done by the range lookup checker; this module makes stimulus and gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_ip_range_binary_lookup;

    localparam int                          CYCLE_LIMIT   = 1_500_000;
    localparam int                          WORD_TARGET   = 2000;
    localparam int                          SMALL_MAX     = 512;
    localparam int                          SETTLE_CYCLES = 40;
    localparam int                          HOLD_CYCLES   = 400;
    localparam logic [iprbl_pkg::CNT_W-1:0] COUNT_MAX     = '1;

    logic                        aclk;
    logic                        aresetn     = 1'b0;
    logic                        cfg_wr_en   = 1'b0;
    logic [iprbl_pkg::CNT_W-1:0] cfg_wr_data = '0;
    logic                        s_tvalid    = 1'b0;
    logic                        s_tready;
    logic [135:0]                s_tdata     = '0;  // entry_index, range_start,
                                                    // range_stop, info_offset,
                                                    // query_address
    logic                        s_tuser     = 1'b0; // mode
    logic                        m_tvalid;
    logic                        m_tready    = 1'b0;
    logic [103:0]                m_tdata;           // hit_index, hit_start,
                                                    // hit_stop, hit_offset
    logic                        m_tuser;           // found
    int                          pending_words;
    int                          fail_count;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int cycle_count   = 0;
    int cur_count     = 0;
    int words_sent    = 0;

    // Ranges as loaded, used only to aim queries at interesting addresses.
    logic [iprbl_pkg::IP_W-1:0] shadow_start [iprbl_pkg::TABLE_DEPTH];
    logic [iprbl_pkg::IP_W-1:0] shadow_stop  [iprbl_pkg::TABLE_DEPTH];

    ip_range_binary_lookup dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    range_lookup_checker lookup_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .pending_words (pending_words),
        .fail_count    (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side readiness: random stalls, or a long hold when one is asked for.
    initial begin : ready_gen
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Give up if the run hangs.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Fixed layout of the full table: one range per 64K block of addresses,
    // with gaps, starting at address zero and ending at the top.
    function automatic logic [iprbl_pkg::IP_W-1:0] fixed_start(input int k);
        logic [iprbl_pkg::IDX_W-1:0] blk;
        blk = iprbl_pkg::IDX_W'(k);
        return (k == 0) ? '0 : {blk, 16'h0100};
    endfunction

    function automatic logic [iprbl_pkg::IP_W-1:0] fixed_stop(input int k);
        logic [iprbl_pkg::IDX_W-1:0] blk;
        blk = iprbl_pkg::IDX_W'(k);
        return (k == iprbl_pkg::TABLE_DEPTH - 1) ? '1 : {blk, 16'hEFFF};
    endfunction

    function automatic logic [iprbl_pkg::OFS_W-1:0] fixed_offset(input int k);
        logic [iprbl_pkg::IDX_W-1:0] blk;
        blk = iprbl_pkg::IDX_W'(k);
        return {8'hA5, blk};
    endfunction

    // Offer one input word, with random gaps ahead of it, until it is taken.
    task automatic send_word(input logic mode, input logic [iprbl_pkg::IDX_W-1:0] idx,
                             input logic [iprbl_pkg::IP_W-1:0] lo,
                             input logic [iprbl_pkg::IP_W-1:0] hi,
                             input logic [iprbl_pkg::OFS_W-1:0] ofs,
                             input logic [iprbl_pkg::IP_W-1:0] addr);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {addr, ofs, hi, lo, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic load_slot(input logic [iprbl_pkg::IDX_W-1:0] idx,
                             input logic [iprbl_pkg::IP_W-1:0] lo,
                             input logic [iprbl_pkg::IP_W-1:0] hi,
                             input logic [iprbl_pkg::OFS_W-1:0] ofs);
        shadow_start[idx] = lo;
        shadow_stop[idx]  = hi;
        send_word(iprbl_pkg::MODE_LOAD, idx, lo, hi, ofs, $urandom);
    endtask

    task automatic load_fixed(input int k);
        load_slot(iprbl_pkg::IDX_W'(k), fixed_start(k), fixed_stop(k), fixed_offset(k));
    endtask

    // Fields other than the address are junk on a query word.
    task automatic query_addr(input logic [iprbl_pkg::IP_W-1:0] addr);
        send_word(iprbl_pkg::MODE_QUERY, iprbl_pkg::IDX_W'($urandom), $urandom,
                  $urandom, iprbl_pkg::OFS_W'($urandom), addr);
    endtask

    // Query against the full table: first load, in the fixed layout, every
    // slot that the search for this address will probe.
    task automatic query_full(input logic [iprbl_pkg::IP_W-1:0] addr);
        int lo;
        int hi;
        int mid;
        bit hit;
        lo  = 0;
        hi  = cur_count - 1;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            load_fixed(mid);
            if (addr < fixed_start(mid)) begin
                hi = mid - 1;
            end else if (addr > fixed_stop(mid)) begin
                lo = mid + 1;
            end else begin
                hit = 1'b1;
            end
        end
        query_addr(addr);
    endtask

    // Wait until every query has answered, then let the block go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_count(input logic [iprbl_pkg::CNT_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_count = (value > iprbl_pkg::SPAN_CAP) ? iprbl_pkg::SPAN_CAP : int'(value);
    endtask

    // Load slots 0 .. n-1 with ascending ranges spread over the address space,
    // leaving gaps between them. The first range starts at address zero and the
    // last one ends at the top. A noisy table gets some inverted or stray ranges.
    task automatic build_table(input int n, input bit noisy);
        logic [63:0]                step;
        logic [63:0]                base;
        logic [iprbl_pkg::IP_W-1:0] lo;
        logic [iprbl_pkg::IP_W-1:0] hi;
        logic [iprbl_pkg::IP_W-1:0] tmp;
        step = 64'h1_0000_0000 / n;
        for (int i = 0; i < n; i++) begin
            base = step * i;
            lo   = base[31:0] + $urandom_range(0, 32'(step / 2 - 1));
            hi   = lo + $urandom_range(0, 32'(step / 2 - 1));
            if (i == 0) lo = '0;
            if (i == n - 1) hi = '1;
            if (noisy && $urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 1) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end else begin
                    lo = $urandom;
                    hi = $urandom;
                end
            end
            load_slot(iprbl_pkg::IDX_W'(i), lo, hi, iprbl_pkg::OFS_W'($urandom));
        end
    endtask

    // Mostly addresses inside or just beside a loaded range, some anywhere.
    function automatic logic [iprbl_pkg::IP_W-1:0] pick_address();
        int                         k;
        logic [iprbl_pkg::IP_W-1:0] lo;
        logic [iprbl_pkg::IP_W-1:0] hi;
        if (cur_count == 0) return $urandom;
        k  = $urandom_range(0, cur_count - 1);
        lo = shadow_start[k];
        hi = shadow_stop[k];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return (hi >= lo) ? lo + $urandom_range(0, hi - lo) : lo;
            5:       return lo;
            6:       return hi;
            7:       return lo - 1;
            8:       return hi + 1;
            default: return $urandom;
        endcase
    endfunction

    // Addresses on or beside a range of the fixed full-table layout, some anywhere.
    function automatic logic [iprbl_pkg::IP_W-1:0] pick_full_address();
        int k;
        k = $urandom_range(0, cur_count - 1);
        case ($urandom_range(0, 4))
            0:       return fixed_start(k);
            1:       return fixed_stop(k);
            2:       return fixed_start(k) - 1;
            3:       return fixed_stop(k) + 1;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int n;
        int sel;
        int queries;
        bit full_table;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table straight after reset, then with the count written to zero.
        query_addr('0);
        query_addr('1);
        set_count('0);
        query_addr(32'h8000_0000);

        // Full table: only the slots on each probe path are loaded.
        set_count(iprbl_pkg::CNT_W'(iprbl_pkg::TABLE_DEPTH));
        query_full('0);
        query_full('1);
        query_full(fixed_start(32768));
        query_full(fixed_stop(100));
        query_full(fixed_stop(5) + 1);

        // Oversized count: the search must stay within the table.
        set_count(COUNT_MAX);
        query_full('1);
        query_full(fixed_start(iprbl_pkg::TABLE_DEPTH - 1) - 1);

        // Single entry: a hit and an address just above it.
        load_fixed(0);
        load_fixed(1);
        set_count(iprbl_pkg::CNT_W'(1));
        query_addr(shadow_stop[0]);
        query_addr(shadow_stop[0] + 1);

        // An inverted range can never match; it pulls the upper bound down or pushes the lower bound up.
        load_slot(iprbl_pkg::IDX_W'(2), 32'h8000_0000, 32'h1000_0000, '1);
        set_count(iprbl_pkg::CNT_W'(3));
        query_addr(32'h2000_0000);
        query_addr(32'h9000_0000);
        query_addr(shadow_start[1]);

        // Random phases, cycling through the idling patterns.
        phase = 0;
        while (words_sent < WORD_TARGET) begin
            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 57;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 57;
                end
                default: begin
                    idle_pct  = 36;
                    stall_pct = 36;
                end
            endcase

            sel = $urandom_range(0, 19);
            if (sel < 14) begin
                n = $urandom_range(1, 48);
            end else if (sel < 17) begin
                n = $urandom_range(49, SMALL_MAX);
            end else begin
                n = 0;
            end
            if (n > 0) begin
                build_table(n, $urandom_range(0, 4) == 0);
                set_count(iprbl_pkg::CNT_W'(n));
            end else if (sel == 17) begin
                set_count('0);
            end else if (sel == 18) begin
                set_count(iprbl_pkg::CNT_W'(iprbl_pkg::TABLE_DEPTH));
            end else begin
                set_count(iprbl_pkg::CNT_W'($urandom_range(iprbl_pkg::TABLE_DEPTH + 1,
                                                           int'(COUNT_MAX))));
            end
            full_table = (cur_count > SMALL_MAX);

            // One long result stall while the sender keeps offering words.
            if (phase == 0) hold_requests++;

            queries = full_table ? $urandom_range(5, 15) : $urandom_range(20, 80);
            repeat (queries) begin
                if ($urandom_range(0, 9) == 0) begin
                    load_slot(iprbl_pkg::IDX_W'($urandom), $urandom, $urandom,
                              iprbl_pkg::OFS_W'($urandom));
                end else if (full_table) begin
                    query_full(pick_full_address());
                end else begin
                    query_addr(pick_address());
                end
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending_words == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
